// ----- src/mssr_pkg.sv -----
// ----------------------------------------------------------------------------
// mssr_pkg
// Shared types and constants of the motor soft-start ramp controller.
// ----------------------------------------------------------------------------
package mssr_pkg;

    localparam logic [7:0] DIVIDE_RESET = 8'd100;

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_FORWARD  = 3'd1;
    localparam logic [2:0] KIND_REVERSE  = 3'd2;
    localparam logic [2:0] KIND_CRITICAL = 3'd3;
    localparam logic [2:0] KIND_SLOWDOWN = 3'd4;
    localparam logic [2:0] KIND_DEFLECT  = 3'd5;

    localparam logic [3:0] LINES_RELEASED = 4'h0;
    localparam logic [3:0] LINES_FORWARD  = 4'h5;
    localparam logic [3:0] LINES_REVERSE  = 4'hA;
    localparam logic [3:0] LINES_PIVOT_23 = 4'h6;
    localparam logic [3:0] LINES_PIVOT_14 = 4'h9;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  step_size;
        logic [7:0]  target_duty;
        logic        turn_dir;
        logic [7:0]  present_duty;
        logic [15:0] turn_interval;
        logic        clear_turn_timer;
    } item_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [3:0] bridge_lines;
        logic       heartbeat;
        logic       stepped;
        logic       stopped;
    } result_t;

endpackage

// ----- src/mssr_in_stage.sv -----
// ----------------------------------------------------------------------------
// mssr_in_stage
// Input register: holds one accepted request until the core consumes it.
// ----------------------------------------------------------------------------
module mssr_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mssr_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output mssr_pkg::item_t item
);
    import mssr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // A new request may enter when none is held or the held one leaves in the same cycle.
    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- src/mssr_core.sv -----
// ----------------------------------------------------------------------------
// mssr_core
// Controller state and its combinational update for one request.
// ----------------------------------------------------------------------------
module mssr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_load,
    input  logic [7:0]        cfg_tick_divide,
    input  logic              advance,
    input  mssr_pkg::item_t   item,
    output mssr_pkg::result_t result
);
    import mssr_pkg::*;

    logic [7:0]  tick_divide_reg;
    logic [7:0]  prescale_reg, prescale_next;
    logic        armed_reg, armed_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  speed_reg, speed_next;
    logic [3:0]  bridge_reg, bridge_next;
    logic        heartbeat_reg, heartbeat_next;
    logic        stepped;

    logic [7:0] prescale_inc;
    logic [8:0] up_sum;
    logic [7:0] up_speed;
    logic       up_ok;
    logic [7:0] down_speed;
    logic       down_ok;
    logic [7:0] slow_speed;
    logic       slow_ok;

    always_comb begin
        prescale_inc = prescale_reg + 8'd1;

        up_sum   = {1'b0, speed_reg} + {1'b0, item.step_size};
        up_speed = (up_sum > {1'b0, item.target_duty}) ? item.target_duty : up_sum[7:0];
        up_ok    = (speed_reg < item.target_duty) && armed_reg;

        down_speed = (speed_reg > item.step_size) ? speed_reg - item.step_size : 8'd0;
        down_ok    = (speed_reg != 8'd0) && armed_reg;

        // Slowdown ramps from the loaded duty and never ends below the floor.
        slow_ok    = (item.present_duty != 8'd0) && armed_reg;
        slow_speed = (item.present_duty > item.step_size) ?
                     item.present_duty - item.step_size : 8'd0;
        if (slow_speed <= item.target_duty) begin
            slow_speed = item.target_duty;
        end
    end

    always_comb begin
        prescale_next  = prescale_reg;
        armed_next     = armed_reg;
        timer_next     = timer_reg;
        speed_next     = speed_reg;
        bridge_next    = bridge_reg;
        heartbeat_next = heartbeat_reg;
        stepped        = 1'b0;

        case (item.kind)
            KIND_TICK: begin
                timer_next = timer_reg + 16'd1;
                if (prescale_inc == tick_divide_reg) begin
                    prescale_next  = 8'd0;
                    armed_next     = 1'b1;
                    heartbeat_next = !heartbeat_reg;
                end else begin
                    prescale_next = prescale_inc;
                end
            end
            KIND_FORWARD, KIND_REVERSE: begin
                bridge_next = (item.kind == KIND_FORWARD) ? LINES_FORWARD : LINES_REVERSE;
                if (up_ok) begin
                    stepped    = 1'b1;
                    armed_next = 1'b0;
                    speed_next = up_speed;
                end
            end
            KIND_CRITICAL: begin
                if (down_ok) begin
                    stepped    = 1'b1;
                    armed_next = 1'b0;
                    speed_next = down_speed;
                    if (down_speed == 8'd0) begin
                        bridge_next = LINES_RELEASED;
                    end
                end
            end
            KIND_SLOWDOWN: begin
                speed_next = item.present_duty;
                if (slow_ok) begin
                    stepped    = 1'b1;
                    armed_next = 1'b0;
                    speed_next = slow_speed;
                end
            end
            KIND_DEFLECT: begin
                bridge_next = item.turn_dir ? LINES_PIVOT_23 : LINES_PIVOT_14;
                if (up_ok && (timer_reg != item.turn_interval)) begin
                    stepped    = 1'b1;
                    armed_next = 1'b0;
                    speed_next = up_speed;
                end
            end
            default: begin
            end
        endcase

        if (item.clear_turn_timer) begin
            timer_next = 16'd0;
        end
    end

    always_comb begin
        result.duty         = speed_next;
        result.bridge_lines = bridge_next;
        result.heartbeat    = heartbeat_next;
        result.stepped      = stepped;
        result.stopped      = (speed_next == 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_divide_reg <= DIVIDE_RESET;
            prescale_reg    <= 8'd0;
            armed_reg       <= 1'b0;
            timer_reg       <= 16'd0;
            speed_reg       <= 8'd0;
            bridge_reg      <= LINES_RELEASED;
            heartbeat_reg   <= 1'b0;
        end else begin
            if (cfg_load) begin
                tick_divide_reg <= cfg_tick_divide;
            end
            if (advance) begin
                prescale_reg  <= prescale_next;
                armed_reg     <= armed_next;
                timer_reg     <= timer_next;
                speed_reg     <= speed_next;
                bridge_reg    <= bridge_next;
                heartbeat_reg <= heartbeat_next;
            end
        end
    end

    // A consumed step needs an armed step and leaves the step disarmed.
    a_step_needs_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stepped |-> armed_reg)
        else $error("step consumed without an armed step");

    a_step_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stepped |=> !armed_reg)
        else $error("step still armed after it was consumed");

    a_speed_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(speed_reg) && $stable(armed_reg))
        else $error("ramp state moved without a request");

    a_heartbeat_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item.kind != KIND_TICK) |=> $stable(heartbeat_reg))
        else $error("heartbeat toggled on a command");

endmodule

// ----- src/mssr_out_stage.sv -----
// ----------------------------------------------------------------------------
// mssr_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mssr_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mssr_pkg::result_t result,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output mssr_pkg::result_t m_result
);
    import mssr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ----- src/motor_soft_start_ramp.sv -----
// ----------------------------------------------------------------------------
// motor_soft_start_ramp
// A request waits in the input register; its result is registered in the
// result register when the request advances through the core.
// Throughput: one request per cycle while the result side is free; the ramp
// state is updated combinationally between the input and result registers.
// Reset clears all ramp state, releases the bridge lines and sets the
// tick divide to 100.
// ----------------------------------------------------------------------------
module motor_soft_start_ramp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [7:0]  s_step_size,
    input  logic [7:0]  s_target_duty,
    input  logic        s_turn_dir,
    input  logic [7:0]  s_present_duty,
    input  logic [15:0] s_turn_interval,
    input  logic        s_clear_turn_timer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_duty,
    output logic [3:0]  m_bridge_lines,
    output logic        m_heartbeat,
    output logic        m_stepped,
    output logic        m_stopped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_tick_divide
);
    import mssr_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    advance;
    result_t result;
    result_t m_result;

    assign s_item.kind             = s_kind;
    assign s_item.step_size        = s_step_size;
    assign s_item.target_duty      = s_target_duty;
    assign s_item.turn_dir         = s_turn_dir;
    assign s_item.present_duty     = s_present_duty;
    assign s_item.turn_interval    = s_turn_interval;
    assign s_item.clear_turn_timer = s_clear_turn_timer;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && out_free;

    mssr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mssr_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_load        (cfg_valid && cfg_ready),
        .cfg_tick_divide (cfg_tick_divide),
        .advance         (advance),
        .item            (item),
        .result          (result)
    );

    mssr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_duty         = m_result.duty;
    assign m_bridge_lines = m_result.bridge_lines;
    assign m_heartbeat    = m_result.heartbeat;
    assign m_stepped      = m_result.stepped;
    assign m_stopped      = m_result.stopped;

endmodule
